/* hw/rtl/shl_pkg.sv */
// Shared types, constants and helper functions of the syntax highlight classifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package shl_pkg;

	localparam int unsigned LOOKAHEAD = 15;
	localparam int unsigned WIN       = LOOKAHEAD + 1;
	localparam int unsigned FILL_W    = $clog2(WIN + 1);
	localparam int unsigned IDX_W     = $clog2(WIN);

	typedef logic [WIN-1:0][7:0] win_t;

	typedef enum logic [2:0] {
		CLS_NORMAL  = 3'd0,
		CLS_COMMENT = 3'd1,
		CLS_KEYWORD = 3'd2,
		CLS_TYPE    = 3'd3,
		CLS_STRING  = 3'd4,
		CLS_NUMBER  = 3'd5
	} token_cls_t;

	// Byte codes with special meaning
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Keyword ROM, searched first hit in this order
	localparam int unsigned NUM_KW    = 11;
	localparam int unsigned KW_MAXLEN = 14;
	localparam int unsigned KW_IW     = $clog2(NUM_KW);
	localparam int unsigned PRE_W     = $clog2(KW_MAXLEN);

	localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [NUM_KW] = '{
		"@sys.disk.read", "@sys", "if", "else", "while", "for", "return",
		"@int", "@str", "@void", "@bool"
	};
	localparam int unsigned KW_LEN [NUM_KW] = '{14, 4, 2, 4, 5, 3, 6, 4, 4, 5, 5};
	localparam token_cls_t KW_CLS [NUM_KW] = '{
		CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
		CLS_KEYWORD, CLS_TYPE, CLS_TYPE, CLS_TYPE, CLS_TYPE
	};

	// Lexer state carried from one head byte to the next
	typedef struct packed {
		logic [7:0]       open_quote;
		logic             after_sep;
		logic             comment;
		logic [PRE_W-1:0] pre_cnt;
		token_cls_t       pre_cls;
		logic             prev_num;
	} lex_state_t;

	localparam lex_state_t LEX_RESET = '{
		open_quote: 8'h00,
		after_sep:  1'b1,
		comment:    1'b0,
		pre_cnt:    '0,
		pre_cls:    CLS_NORMAL,
		prev_num:   1'b0
	};

	// Window occupancy seen by the handshake logic
	typedef struct packed {
		logic full;
		logic flushing;
		logic nonempty;
		logic last;
	} win_status_t;

	function automatic logic is_sep(input logic [7:0] c);
		logic r;
		r = 1'b0;
		case (c)
			8'h00, 8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: r = 1'b1;
			8'h2C, 8'h2E, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A: r = 1'b1;
			8'h3D, 8'h7E, 8'h25, 8'h5B, 8'h5D, 8'h3B, 8'h7B, 8'h7D: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Keyword j sits at the head of the window and is followed by a separator
	function automatic logic kw_match(input win_t w, input int unsigned j);
		logic hit;
		hit = 1'b1;
		for (int unsigned m = 0; m < KW_MAXLEN; m++) begin
			if (m < KW_LEN[j]) begin
				if (w[m] != KW_TEXT[j][(KW_LEN[j] - 1 - m) * 8 +: 8]) begin
					hit = 1'b0;
				end
			end
		end
		return hit && is_sep(w[IDX_W'(KW_LEN[j])]);
	endfunction

endpackage

/* hw/rtl/syntax_highlight_classifier_core.sv */
// Syntax highlight classifier top level: handshakes, enable register, result register.
// Depends on shl_pkg, shl_window and shl_classify.
//
// Usage:
//  Input channel (in_valid / in_stall) takes one byte of a row per item, with
//  row_end set on the row's final byte. Output channel (out_valid / out_stall)
//  gives one item per input byte, in byte order: token_class and row_done.
//  Throughput is one item per cycle while out_stall is low and no flush runs.
//  A byte's class is registered in the result register once LOOKAHEAD
//  further bytes of the row are held in the window, or during the flush after
//  the row ends. The flush drains the window at one item per cycle while
//  out_stall is low, up to LOOKAHEAD + 1 items; in_stall stays high until the
//  last item of the row is registered, so the next row waits for the drain.
//  cfg_write / cfg_data write highlight_enable; while it reads 0, every class
//  is sent as normal. Write it only when the block is idle.
//  Reset clears the window, the lexer state and the output valid flag, and sets
//  highlight_enable. When out_stall holds the result register full and the
//  window is full, in_stall rises and nothing is lost.
`timescale 1ns / 1ps

module syntax_highlight_classifier_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       row_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] token_class,
	output logic       row_done
);
	import shl_pkg::*;

	win_t        window;
	win_status_t win_st;
	token_cls_t  head_cls;
	logic        enable_q;
	logic        out_valid_q, row_done_q;
	logic [2:0]  token_class_q;
	logic        out_free, emit, accept;

	// result register can take a new item when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	// classify the head when the window is full or the row is flushing, and the result register is free
	assign emit     = (win_st.full || (win_st.flushing && win_st.nonempty)) && out_free;
	// hold input during flush and when a full window cannot advance
	assign in_stall = win_st.flushing || (win_st.full && !emit);
	assign accept   = in_valid && !in_stall;

	shl_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.row_end   (row_end),
		.emit      (emit),
		.window    (window),
		.status    (win_st)
	);

	shl_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.window   (window),
		.advance  (emit),
		.row_last (win_st.last),
		.cls      (head_cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_write) begin
			enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	// payload: advance only with a new item
	always_ff @(posedge clk) begin
		if (emit) begin
			token_class_q <= enable_q ? head_cls : CLS_NORMAL;
			row_done_q    <= win_st.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_class = token_class_q;
	assign row_done    = row_done_q;

`ifndef ASSERT_OFF
	// the last item of a row ends the flush
	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && win_st.last |=> !win_st.flushing)
		else $error("flush still active after last item of row");

	// a row end that is taken starts the flush
	a_flush_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_end |=> win_st.flushing)
		else $error("row end accepted without flush");

	// a full window behind a blocked result register takes no byte
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		win_st.full && out_valid_q && out_stall |-> in_stall)
		else $error("input accepted into a full window");

	// the row_done item leaves an empty window behind
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		emit && win_st.last |=> !win_st.nonempty)
		else $error("window not empty after row end");

	// classes stay within the defined codes
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (token_class_q <= 3'd5))
		else $error("undefined token class");
`endif

endmodule

/* hw/rtl/shl_window.sv */
// Lookahead window of the syntax highlight classifier: byte shift line, fill count, row end.
// Depends on shl_pkg.
`timescale 1ns / 1ps

module shl_window (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          text_byte,
	input  logic                row_end,
	input  logic                emit,
	output shl_pkg::win_t       window,
	output shl_pkg::win_status_t status
);
	import shl_pkg::*;

	win_t              win_q, win_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [IDX_W-1:0]  wr_ptr;
	logic              end_q, end_d;

	assign status.full     = (fill_q == FILL_W'(WIN));
	assign status.flushing = end_q;
	assign status.nonempty = (fill_q != '0);
	assign status.last     = end_q && (fill_q == FILL_W'(1));
	assign window          = win_q;

	always_comb begin
		win_d  = win_q;
		fill_d = fill_q;
		end_d  = end_q;
		// drop the head byte and pull in a zero at the far end
		if (emit) begin
			for (int unsigned i = 0; i < WIN - 1; i++) begin
				win_d[i] = win_q[i+1];
			end
			win_d[WIN-1] = CH_NUL;
			fill_d       = fill_q - FILL_W'(1);
		end
		wr_ptr = fill_d[IDX_W-1:0];
		if (accept) begin
			win_d[wr_ptr] = text_byte;
			fill_d        = fill_d + FILL_W'(1);
			end_d         = row_end;
		end
		if (emit && status.last) begin
			end_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
			end_q  <= 1'b0;
		end else begin
			win_q  <= win_d;
			fill_q <= fill_d;
			end_q  <= end_d;
		end
	end

endmodule

/* hw/rtl/shl_classify.sv */
// Head byte classifier: comment, string, number and keyword rules plus the lexer state.
// Depends on shl_pkg.
`timescale 1ns / 1ps

module shl_classify (
	input  logic                clk,
	input  logic                arst_n,
	input  shl_pkg::win_t       window,
	input  logic                advance,
	input  logic                row_last,
	output shl_pkg::token_cls_t cls
);
	import shl_pkg::*;

	lex_state_t       st_q, st_d;
	logic [7:0]       head;
	logic             comment_start, escape, quote, digit;
	logic [NUM_KW-1:0] kw_hit;
	logic [KW_IW-1:0] kw_sel;
	logic             kw_any;

	assign head          = window[0];
	assign comment_start = (head == CH_SLASH) && (window[1] == CH_DASH) && (window[2] == CH_DASH);
	assign escape        = (head == CH_BSLASH) && (window[1] != CH_NUL);
	assign quote         = (head == CH_DQUOTE) || (head == CH_SQUOTE);
	assign digit         = (head >= CH_ZERO) && (head <= CH_NINE);

	// all ROM entries compare in parallel, lowest index wins
	always_comb begin
		for (int unsigned j = 0; j < NUM_KW; j++) begin
			kw_hit[j] = kw_match(window, j);
		end
		kw_sel = '0;
		for (int j = NUM_KW - 1; j >= 0; j--) begin
			if (kw_hit[j]) begin
				kw_sel = KW_IW'(j);
			end
		end
		kw_any = |kw_hit;
	end

	always_comb begin
		st_d = st_q;
		cls  = CLS_NORMAL;
		priority if (st_q.pre_cnt != '0) begin
			cls          = st_q.pre_cls;
			st_d.pre_cnt = st_q.pre_cnt - PRE_W'(1);
		end else if (st_q.comment) begin
			cls = CLS_COMMENT;
		end else if (comment_start) begin
			cls          = CLS_COMMENT;
			st_d.comment = 1'b1;
		end else if (st_q.open_quote != CH_NUL) begin
			cls = CLS_STRING;
			if (escape) begin
				st_d.pre_cnt = PRE_W'(1);
				st_d.pre_cls = CLS_STRING;
			end else if (head == st_q.open_quote) begin
				st_d.open_quote = CH_NUL;
			end
		end else if (quote) begin
			cls             = CLS_STRING;
			st_d.open_quote = head;
			st_d.after_sep  = 1'b0;
		end else if (digit && (st_q.after_sep || st_q.prev_num)) begin
			cls            = CLS_NUMBER;
			st_d.after_sep = 1'b0;
		end else if (st_q.after_sep && kw_any) begin
			// rest of the keyword takes the same class
			cls            = KW_CLS[kw_sel];
			st_d.pre_cls   = KW_CLS[kw_sel];
			st_d.pre_cnt   = PRE_W'(KW_LEN[kw_sel] - 1);
			st_d.after_sep = 1'b0;
		end else begin
			st_d.after_sep = is_sep(head);
		end
		st_d.prev_num = (cls == CLS_NUMBER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LEX_RESET;
		end else if (advance) begin
			st_q <= row_last ? LEX_RESET : st_d;
		end
	end

endmodule

/* test/tb_syntax_highlight_classifier_core.sv */
// Self-checking testbench for syntax_highlight_classifier_core: directed rows, then random rows.
// Depends on shl_pkg (token classes, byte codes, window size) and the core RTL only.
`timescale 1ns / 1ps

module tb_syntax_highlight_classifier_core;

	import shl_pkg::*;

	// Longest quiet stretch in a correct run is the long receiver hold (HOLD_LONG)
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_LONG   = 300;
	localparam int NUM_WORDS   = 11;
	localparam int DIR_N       = 28;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_write = 1'b0;
	logic       cfg_data  = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte = 8'h00;
	logic       row_end   = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] token_class;
	logic       row_done;

	syntax_highlight_classifier_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.row_end     (row_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_class (token_class),
		.row_done    (row_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Classifier shadow: window of pending bytes, lexer flags, enable.
	// ------------------------------------------------------------------
	string      kw_word [NUM_WORDS] = '{"@sys.disk.read", "@sys", "if", "else", "while", "for",
		"return", "@int", "@str", "@void", "@bool"};
	token_cls_t kw_kind [NUM_WORDS] = '{CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
		CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_TYPE, CLS_TYPE, CLS_TYPE, CLS_TYPE};
	string      sep_set = ",.()+-/*=~%[];{}";

	logic [7:0]  win_byte [WIN];
	token_cls_t  win_pre [WIN];
	logic [7:0]  quote_ch;
	bit          sep_seen;
	bit          in_comment;
	bit          last_num;
	int unsigned pre_left;
	int unsigned fill;
	bit          enable_shadow;

	// Expected results, oldest first; typed-in classes of directed bytes ride along
	token_cls_t want_class_q [$];
	logic       want_done_q [$];
	int         typed_class_q [$];

	logic [7:0] row_buf [$];
	int         sent_bytes  = 0;
	int         mismatches  = 0;
	int         quiet_cycles = 0;
	bit         tx_bursty   = 1'b1;
	bit         rx_bursty   = 1'b1;
	bit         rx_long_req = 1'b0;
	int         rx_hold_left = 0;

	function automatic void lex_clear_row();
		int k;
		for (k = 0; k < WIN; k++) begin
			win_byte[k] = CH_NUL;
			win_pre[k]  = CLS_NORMAL;
		end
		quote_ch   = CH_NUL;
		sep_seen   = 1'b1;
		in_comment = 1'b0;
		last_num   = 1'b0;
		pre_left   = 0;
		fill       = 0;
	endfunction

	// Byte at offset k from the head; beyond the known end of the row reads as zero
	function automatic logic [7:0] look(int unsigned k);
		if (k < fill && k < WIN) begin
			return win_byte[k];
		end
		return CH_NUL;
	endfunction

	function automatic bit sep_byte(logic [7:0] c);
		int k;
		if (c == CH_NUL || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
			return 1'b1;
		end
		for (k = 0; k < sep_set.len(); k++) begin
			if (c == sep_set[k]) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Class of the head byte when no keyword or escape has already fixed it
	function automatic token_cls_t lex_head_class();
		logic [7:0]  b;
		bit          hit;
		int unsigned j, m, n;
		b = look(0);
		if (in_comment) begin
			return CLS_COMMENT;
		end
		if (b == CH_SLASH && look(1) == CH_DASH && look(2) == CH_DASH) begin
			in_comment = 1'b1;
			return CLS_COMMENT;
		end
		if (quote_ch != CH_NUL) begin
			// an escape claims the following byte as string too, unless nothing follows
			if (b == CH_BSLASH && look(1) != CH_NUL) begin
				win_pre[1] = CLS_STRING;
				pre_left   = 1;
				return CLS_STRING;
			end
			if (b == quote_ch) begin
				quote_ch = CH_NUL;
			end
			return CLS_STRING;
		end
		if (b == CH_DQUOTE || b == CH_SQUOTE) begin
			quote_ch = b;
			sep_seen = 1'b0;
			return CLS_STRING;
		end
		if (b >= CH_ZERO && b <= CH_NINE && (sep_seen || last_num)) begin
			sep_seen = 1'b0;
			return CLS_NUMBER;
		end
		if (sep_seen) begin
			// first word of the list wins; it must be followed by a separator
			for (j = 0; j < NUM_WORDS; j++) begin
				n   = kw_word[j].len();
				hit = 1'b1;
				for (m = 0; m < n; m++) begin
					if (look(m) != kw_word[j][m]) begin
						hit = 1'b0;
					end
				end
				if (hit && sep_byte(look(n))) begin
					for (m = 1; m < n && m < WIN; m++) begin
						win_pre[m] = kw_kind[j];
					end
					pre_left = n - 1;
					sep_seen = 1'b0;
					return kw_kind[j];
				end
			end
		end
		sep_seen = sep_byte(b);
		return CLS_NORMAL;
	endfunction

	// Take one accepted byte; queue the results it releases from the window
	function automatic void lex_push_byte(logic [7:0] b, logic e);
		token_cls_t c;
		int         typed;
		int         k;
		if (fill < WIN) begin
			win_byte[fill] = b;
			fill++;
		end
		while (fill > LOOKAHEAD || (e && fill > 0)) begin
			if (pre_left > 0) begin
				c = win_pre[0];
				pre_left--;
			end else begin
				c = lex_head_class();
			end
			last_num = (c == CLS_NUMBER);
			typed    = typed_class_q.pop_front();
			if (typed >= 0) begin
				want_class_q.push_back(token_cls_t'(typed));
			end else begin
				want_class_q.push_back(enable_shadow ? c : CLS_NORMAL);
			end
			want_done_q.push_back(e && fill == 1);
			for (k = 0; k < WIN - 1; k++) begin
				win_byte[k] = win_byte[k + 1];
				win_pre[k]  = win_pre[k + 1];
			end
			win_byte[WIN - 1] = CH_NUL;
			win_pre[WIN - 1]  = CLS_NORMAL;
			fill--;
		end
		if (e) begin
			lex_clear_row();
		end
	endfunction

	// ------------------------------------------------------------------
	// Random rows: keywords, numbers, strings with escapes, comments,
	// names, separators and noise, so most rows get deep into the lexer.
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_letter();
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic void add_token();
		int         j, k, n;
		logic [7:0] q;
		case ($urandom_range(0, 11))
			0, 1, 2: begin
				j = $urandom_range(0, NUM_WORDS - 1);
				for (k = 0; k < kw_word[j].len(); k++) begin
					row_buf.push_back(kw_word[j][k]);
				end
				// spoil the match now and then
				if ($urandom_range(0, 4) == 0) begin
					row_buf.push_back(rand_letter());
				end
			end
			3, 4: begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++) begin
					row_buf.push_back(rand_digit());
				end
			end
			5: begin
				q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
				row_buf.push_back(q);
				n = $urandom_range(0, 5);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(0, 5))
						0: begin
							row_buf.push_back(CH_BSLASH);
							row_buf.push_back(q);
						end
						1: row_buf.push_back(CH_BSLASH);
						2: row_buf.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
						3: row_buf.push_back(rand_digit());
						default: row_buf.push_back(rand_letter());
					endcase
				end
				if ($urandom_range(0, 3) != 0) begin
					row_buf.push_back(q);
				end
			end
			6: begin
				row_buf.push_back(CH_SLASH);
				row_buf.push_back(CH_DASH);
				if ($urandom_range(0, 3) != 0) begin
					row_buf.push_back(CH_DASH);
				end
			end
			7, 8: begin
				n = $urandom_range(1, 5);
				row_buf.push_back(rand_letter());
				for (k = 1; k < n; k++) begin
					row_buf.push_back($urandom_range(0, 2) ? rand_letter() : rand_digit());
				end
			end
			9: begin
				if ($urandom_range(0, 3) == 0) begin
					row_buf.push_back(8'($urandom_range(9, 13)));
				end else begin
					row_buf.push_back(sep_set[$urandom_range(0, sep_set.len() - 1)]);
				end
			end
			10: row_buf.push_back(" ");
			default: row_buf.push_back(8'($urandom_range(1, 255)));
		endcase
		if ($urandom_range(0, 1) == 0) begin
			row_buf.push_back(" ");
		end
	endfunction

	function automatic void build_row(int want);
		row_buf.delete();
		while (row_buf.size() < want) begin
			add_token();
		end
	endfunction

	// Mostly short rows; some run past the lookahead so results stream mid-row
	function automatic int row_len();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(21, 50) : $urandom_range(1, 20);
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one byte and hold it until accepted; typed < 0 leaves the class to the shadow
	task automatic push_byte(input logic [7:0] b, input logic e, input int typed);
		if (tx_bursty && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		row_end   <= e;
		do @(posedge clk); while (in_stall);
		typed_class_q.push_back(typed);
		lex_push_byte(b, e);
		sent_bytes++;
	endtask

	task automatic send_row();
		int k;
		for (k = 0; k < row_buf.size(); k++) begin
			push_byte(row_buf[k], k == row_buf.size() - 1, -1);
		end
	endtask

	// Drop valid, let every expected item drain, then give the window time to settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (want_class_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (LOOKAHEAD + 4) @(posedge clk);
	endtask

	task automatic write_enable(input logic v);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write     <= 1'b0;
		enable_shadow = v;
	endtask

	// ------------------------------------------------------------------
	// Directed rows. Classes are typed in where they are plain to see;
	// the quote row is left to the shadow. Once the quote row has fully
	// drained, highlighting is switched off, so the "for" row that
	// follows must come out all normal.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [7:0] ch;
		logic       row_last;
		logic       typed;
		token_cls_t cls;
		logic       then_disable;
	} dir_item_t;

	dir_item_t dir_items [DIR_N] = '{
		'{"i",    1'b0, 1'b1, CLS_KEYWORD, 1'b0},
		'{"f",    1'b0, 1'b1, CLS_KEYWORD, 1'b0},
		'{" ",    1'b0, 1'b1, CLS_NORMAL,  1'b0},
		'{"7",    1'b1, 1'b1, CLS_NUMBER,  1'b0},
		'{"/",    1'b0, 1'b1, CLS_COMMENT, 1'b0},
		'{"-",    1'b0, 1'b1, CLS_COMMENT, 1'b0},
		'{"-",    1'b0, 1'b1, CLS_COMMENT, 1'b0},
		'{"\"",   1'b1, 1'b1, CLS_COMMENT, 1'b0},
		'{"\"",   1'b0, 1'b1, CLS_STRING,  1'b0},
		'{"\\",   1'b0, 1'b1, CLS_STRING,  1'b0},
		'{"\"",   1'b0, 1'b1, CLS_STRING,  1'b0},
		'{"\"",   1'b1, 1'b1, CLS_STRING,  1'b0},
		'{8'hFF,  1'b0, 1'b1, CLS_NORMAL,  1'b0},
		'{8'h01,  1'b1, 1'b1, CLS_NORMAL,  1'b0},
		'{8'h00,  1'b0, 1'b1, CLS_NORMAL,  1'b0},
		'{"5",    1'b1, 1'b1, CLS_NUMBER,  1'b0},
		'{"@",    1'b0, 1'b1, CLS_TYPE,    1'b0},
		'{"i",    1'b0, 1'b1, CLS_TYPE,    1'b0},
		'{"n",    1'b0, 1'b1, CLS_TYPE,    1'b0},
		'{"t",    1'b0, 1'b1, CLS_TYPE,    1'b0},
		'{";",    1'b1, 1'b1, CLS_NORMAL,  1'b0},
		'{"'",    1'b0, 1'b0, CLS_NORMAL,  1'b0},
		'{"a",    1'b1, 1'b0, CLS_NORMAL,  1'b1},
		'{"f",    1'b0, 1'b1, CLS_NORMAL,  1'b0},
		'{"o",    1'b0, 1'b1, CLS_NORMAL,  1'b0},
		'{"r",    1'b0, 1'b1, CLS_NORMAL,  1'b0},
		'{" ",    1'b0, 1'b1, CLS_NORMAL,  1'b0},
		'{"9",    1'b1, 1'b1, CLS_NORMAL,  1'b0}
	};

	// ------------------------------------------------------------------
	// Output side: check each accepted item, then pick the next stall.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (want_class_q.size() == 0) begin
				$error("unexpected item: token_class %0d row_done %0b", token_class, row_done);
				mismatches++;
			end else begin
				if (token_class !== want_class_q[0]) begin
					$error("token_class: expected %0d, actual %0d", want_class_q[0], token_class);
					mismatches++;
				end
				if (row_done !== want_done_q[0]) begin
					$error("row_done: expected %0b, actual %0b", want_done_q[0], row_done);
					mismatches++;
				end
				void'(want_class_q.pop_front());
				void'(want_done_q.pop_front());
			end
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_stall <= 1'b1;
		end else if (rx_long_req) begin
			// long hold: window and result register fill, input must stall
			rx_long_req  = 1'b0;
			rx_hold_left = HOLD_LONG - 1;
			out_stall    <= 1'b1;
		end else if (rx_bursty && $urandom_range(0, 9) == 0) begin
			rx_hold_left = $urandom_range(0, 14);
			out_stall    <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: end the run if no item moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_syntax_highlight_classifier_core failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		enable_shadow = 1'b1;
		lex_clear_row();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_items[i]) begin
			push_byte(dir_items[i].ch, dir_items[i].row_last,
				dir_items[i].typed ? int'(dir_items[i].cls) : -1);
			if (dir_items[i].then_disable) begin
				wait_idle();
				write_enable(1'b0);
			end
		end
		wait_idle();
		write_enable(1'b1);

		// random rows, highlighting on, idling on both sides
		while (sent_bytes < 80) begin
			build_row(row_len());
			send_row();
		end
		// sender pause: hold off until every result is back
		wait_idle();
		// long receiver hold while a long row keeps coming
		rx_long_req = 1'b1;
		build_row(45);
		send_row();
		while (sent_bytes < 150) begin
			build_row(row_len());
			send_row();
		end

		// highlighting off
		wait_idle();
		write_enable(1'b0);
		while (sent_bytes < 185) begin
			build_row(row_len());
			send_row();
		end

		wait_idle();
		write_enable(1'b1);
		while (sent_bytes < 220) begin
			build_row(row_len());
			send_row();
		end

		// last stretch at full rate on both sides
		tx_bursty = 1'b0;
		rx_bursty = 1'b0;
		while (sent_bytes < 255) begin
			build_row(row_len());
			send_row();
		end

		wait_idle();
		if (mismatches == 0 && want_class_q.size() == 0) begin
			$display("tb_syntax_highlight_classifier_core passed");
		end else begin
			$display("tb_syntax_highlight_classifier_core failed");
		end
		$finish;
	end

endmodule
